@@ hdl/sfd_pkg.sv @@
// Shared types and constants for the sync-framed sensor packet deframer.
// No dependencies; sfd_core and the deframer top level import this package.
`default_nettype none

package sfd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned SYNC_W     = 32;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = SYNC_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_WORD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_VER = 2'd1;

  localparam logic [SYNC_W-1:0] SYNC_WORD_RST = 32'hdead_beef;
  localparam logic [BYTE_W-1:0] EXP_VER_RST   = 8'h02;

  // Byte positions within a frame
  localparam logic [IDX_W-1:0] POS_SYNC_START = 4'd1;
  localparam logic [IDX_W-1:0] POS_SYNC_LAST  = 4'd3;
  localparam logic [IDX_W-1:0] POS_VERSION    = 4'd4;
  localparam logic [IDX_W-1:0] POS_PRESS_LO   = 4'd7;
  localparam logic [IDX_W-1:0] POS_PRESS_HI   = 4'd8;
  localparam logic [IDX_W-1:0] POS_TEMP_LO    = 4'd9;
  localparam logic [IDX_W-1:0] POS_TEMP_HI    = 4'd10;
  localparam logic [IDX_W-1:0] POS_STATUS     = 4'd11;
  localparam logic [IDX_W-1:0] POS_CHECK      = 4'd12;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_SYNC    = 2'd1,
    PH_VERSION = 2'd2,
    PH_BODY    = 2'd3
  } phase_t;

  typedef struct packed {
    logic [WORD_W-1:0] pressure_raw;
    logic [WORD_W-1:0] temperature_raw;
    logic [BYTE_W-1:0] sensor_status;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/sfd_ifs.sv @@
// Valid/ready channel interfaces for the deframer's byte input and result output.
// No dependencies.
`default_nettype none

interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pressure_raw;
  logic [15:0] temperature_raw;
  logic [7:0]  sensor_status;

  modport source (output valid, output pressure_raw, output temperature_raw,
                  output sensor_status, input ready);
  modport sink   (input valid, input pressure_raw, input temperature_raw,
                  input sensor_status, output ready);
endinterface

`default_nettype wire

@@ hdl/sfd_core.sv @@
// Frame state machine, running checksum and field capture of the deframer.
// Depends on sfd_pkg.
`default_nettype none

module sfd_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        byte_en,
  input  wire logic [sfd_pkg::BYTE_W-1:0]  rx_byte,
  input  wire logic [sfd_pkg::SYNC_W-1:0]  sync_word,
  input  wire logic [sfd_pkg::BYTE_W-1:0]  expected_version,
  output logic                             emit,
  output sfd_pkg::result_t                 result
);
  import sfd_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [BYTE_W-1:0]   sum_r, sum_nxt;
  logic [SYNC_W-1:0]   sync_r, sync_nxt;
  logic [WORD_W-1:0]   press_r;
  logic [WORD_W-1:0]   temp_r;
  logic [BYTE_W-1:0]   status_r;
  logic [SYNC_W-1:0]   sync_shift;

  assign sync_shift = {rx_byte, sync_r[SYNC_W-1:BYTE_W]};

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    sum_nxt   = sum_r;
    sync_nxt  = sync_r;
    emit      = 1'b0;
    if (byte_en) begin
      case (phase_r)
        PH_HUNT: begin
          if (rx_byte == sync_word[BYTE_W-1:0]) begin
            phase_nxt = PH_SYNC;
            idx_nxt   = POS_SYNC_START;
            sum_nxt   = rx_byte;
            sync_nxt  = sync_shift;
          end
        end
        PH_SYNC: begin
          sync_nxt = sync_shift;
          sum_nxt  = sum_r + rx_byte;
          idx_nxt  = idx_r + 4'd1;
          if (idx_r == POS_SYNC_LAST) begin
            if (sync_shift == sync_word) begin
              phase_nxt = PH_VERSION;
            end else begin
              phase_nxt = PH_HUNT;
              idx_nxt   = '0;
              sum_nxt   = '0;
            end
          end
        end
        PH_VERSION: begin
          if (rx_byte == expected_version) begin
            phase_nxt = PH_BODY;
            idx_nxt   = POS_VERSION + 4'd1;
            sum_nxt   = sum_r + rx_byte;
          end else begin
            phase_nxt = PH_HUNT;
            idx_nxt   = '0;
            sum_nxt   = '0;
          end
        end
        PH_BODY: begin
          if (idx_r >= POS_CHECK) begin
            // checksum byte: compare, never add; restart either way
            emit      = (rx_byte == sum_r);
            phase_nxt = PH_HUNT;
            idx_nxt   = '0;
            sum_nxt   = '0;
          end else begin
            sum_nxt = sum_r + rx_byte;
            idx_nxt = idx_r + 4'd1;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
          idx_nxt   = '0;
          sum_nxt   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      idx_r   <= '0;
      sum_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // Captured frame bytes: no reset, each read only after written in the frame
  always_ff @(posedge clk) begin
    sync_r <= sync_nxt;
    if (byte_en && phase_r == PH_BODY) begin
      case (idx_r)
        POS_PRESS_LO: press_r[BYTE_W-1:0]       <= rx_byte;
        POS_PRESS_HI: press_r[WORD_W-1:BYTE_W]  <= rx_byte;
        POS_TEMP_LO:  temp_r[BYTE_W-1:0]        <= rx_byte;
        POS_TEMP_HI:  temp_r[WORD_W-1:BYTE_W]   <= rx_byte;
        POS_STATUS:   status_r                  <= rx_byte;
        default: begin
        end
      endcase
    end
  end

  assign result.pressure_raw    = press_r;
  assign result.temperature_raw = temp_r;
  assign result.sensor_status   = status_r;

`ifndef SYNTHESIS
  a_emit_only_on_check: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (phase_r == PH_BODY && idx_r == POS_CHECK))
    else $error("result raised outside the checksum byte");

  a_hunt_after_check: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_en && phase_r == PH_BODY && idx_r == POS_CHECK) |=>
      (phase_r == PH_HUNT && idx_r == '0 && sum_r == '0))
    else $error("no restart after checksum byte");

  a_sync_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SYNC) |-> (idx_r >= POS_SYNC_START && idx_r <= POS_SYNC_LAST))
    else $error("sync byte index out of range");

  a_body_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> (idx_r > POS_VERSION && idx_r <= POS_CHECK))
    else $error("body byte index out of range");
`endif

endmodule

`default_nettype wire

@@ hdl/sync_framed_sensor_packet_deframer_top.sv @@
// A checksum byte is held in the input byte register until the result register can take a
// result; the frame logic then loads the result register, which offers it on out_ch.
// Throughput: one byte per cycle while the result side takes results when offered.
// Stages: input byte register, then frame logic into the result register.
// Reset (rst_n, synchronous): back to hunting, registers to 0xdeadbeef and version 2.
// Top level of the deframer; depends on sfd_pkg, sfd_ifs and sfd_core.
`default_nettype none

module sync_framed_sensor_packet_deframer_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [sfd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sfd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  sfd_in_if.sink                                 in_ch,
  sfd_out_if.source                              out_ch
);
  import sfd_pkg::*;

  logic [SYNC_W-1:0] sync_word_r;
  logic [BYTE_W-1:0] exp_ver_r;
  logic              in_vld_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              out_vld_r, out_vld_nxt;
  result_t           res_r;
  result_t           core_res;
  logic              core_emit;
  logic              proc_go;
  logic              byte_en;
  logic              in_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_word_r <= SYNC_WORD_RST;
      exp_ver_r   <= EXP_VER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_WORD:    sync_word_r <= cfg_wdata;
        CFG_EXPECTED_VER: exp_ver_r   <= cfg_wdata[BYTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Process the held byte only when the result register can take a request
  assign proc_go       = ~out_vld_r | out_ch.ready;
  assign byte_en       = in_vld_r & proc_go;
  assign in_ch.ready   = ~in_vld_r | proc_go;
  assign in_take       = in_ch.valid & in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_ch.rx_byte;
    end
  end

  sfd_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .byte_en          (byte_en),
    .rx_byte          (in_byte_r),
    .sync_word        (sync_word_r),
    .expected_version (exp_ver_r),
    .emit             (core_emit),
    .result           (core_res)
  );

  always_comb begin
    out_vld_nxt = out_vld_r & ~out_ch.ready;
    if (core_emit) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (core_emit) begin
      res_r <= core_res;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.pressure_raw    = res_r.pressure_raw;
  assign out_ch.temperature_raw = res_r.temperature_raw;
  assign out_ch.sensor_status   = res_r.sensor_status;

`ifndef SYNTHESIS
  a_hold_unprocessed_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !proc_go) |=> (in_vld_r && $stable(in_byte_r)))
    else $error("held input byte lost before processing");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    core_emit |-> (!out_vld_r || out_ch.ready))
    else $error("result raised while previous result still pending");

  a_emit_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    core_emit |-> byte_en)
    else $error("result raised without a byte in process");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the sync-framed sensor packet deframer.
// Depends on hdl/sfd_pkg.sv, hdl/sfd_ifs.sv and the deframer top level;
// feeds directed and random byte streams and checks each decoded packet.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sfd_pkg::*;

  localparam int N_PHASES   = 6;
  localparam int PHASE_LEN  = 200;
  localparam int LONG_HOLD  = 300;
  localparam int DRAIN_GAP  = 4;
  localparam int ERR_PRINTS = 40;

  // Indexes past the register list; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_QUIET,
    CHK_FRAME
  } chk_t;

  typedef struct {
    logic [7:0] rx;
    chk_t       kind;
    result_t    pkt;
  } dir_row_t;

  localparam int N_DIR = 26;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sfd_in_if  byte_if ();
  sfd_out_if pkt_if ();

  sync_framed_sensor_packet_deframer_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (byte_if),
    .out_ch    (pkt_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Restart byte not re-examined, a wrong version, then a good frame at the extremes
  dir_row_t dir_tab [N_DIR] = '{
    '{8'hEF, CHK_MODEL, '0}, '{8'hBE, CHK_MODEL, '0}, '{8'hAD, CHK_MODEL, '0},
    '{8'hEF, CHK_MODEL, '0}, '{8'hBE, CHK_MODEL, '0}, '{8'hAD, CHK_MODEL, '0},
    '{8'hDE, CHK_MODEL, '0}, '{8'h02, CHK_MODEL, '0},
    '{8'hEF, CHK_QUIET, '0}, '{8'hBE, CHK_QUIET, '0}, '{8'hAD, CHK_QUIET, '0},
    '{8'hDE, CHK_QUIET, '0}, '{8'h03, CHK_QUIET, '0},
    '{8'hEF, CHK_QUIET, '0}, '{8'hBE, CHK_QUIET, '0}, '{8'hAD, CHK_QUIET, '0},
    '{8'hDE, CHK_QUIET, '0}, '{8'h02, CHK_QUIET, '0}, '{8'hFF, CHK_QUIET, '0},
    '{8'hFF, CHK_QUIET, '0}, '{8'hFF, CHK_QUIET, '0}, '{8'hFF, CHK_QUIET, '0},
    '{8'h00, CHK_QUIET, '0}, '{8'h00, CHK_QUIET, '0}, '{8'hFF, CHK_QUIET, '0},
    '{8'h35, CHK_FRAME, '{16'hFFFF, 16'h0000, 8'hFF}}
  };

  // Deframer state and register copies
  logic [SYNC_W-1:0] sync_cfg;
  logic [7:0]        ver_cfg;
  phase_t            ph;
  logic [IDX_W-1:0]  idx;
  logic [7:0]        sum;
  logic [7:0]        frm [16];

  result_t pending_pkts [$];
  result_t want_pkt;

  int  n_errors = 0;
  int  bytes_sent = 0;
  int  pkts_checked = 0;
  int  n_writes = 0;
  bit  calm = 1'b0;
  bit  hold_req = 1'b0;

  task automatic flag(input string what);
    if (n_errors < ERR_PRINTS)
      $display("MISMATCH @%0t: %s", $realtime, what);
    n_errors++;
  endtask

  function automatic void restart_hunt();
    ph  = PH_HUNT;
    idx = '0;
    sum = '0;
  endfunction

  function automatic void take_byte(input logic [7:0] b);
    frm[idx] = b;
    sum      = sum + b;
    idx      = idx + 1'b1;
  endfunction

  task automatic deframe_byte(input logic [7:0] b, output bit got, output result_t r);
    got = 1'b0;
    r   = '0;
    case (ph)
      PH_HUNT: begin
        if (b == sync_cfg[7:0]) begin
          restart_hunt();
          take_byte(b);
          ph = PH_SYNC;
        end
      end
      PH_SYNC: begin
        // four sync bytes end just short of the version position
        if (idx < POS_VERSION)
          take_byte(b);
        if (idx >= POS_VERSION) begin
          if ({frm[3], frm[2], frm[1], frm[0]} == sync_cfg)
            ph = PH_VERSION;
          else
            restart_hunt();
        end
      end
      PH_VERSION: begin
        idx = POS_VERSION;
        take_byte(b);
        if (b == ver_cfg)
          ph = PH_BODY;
        else
          restart_hunt();
      end
      default: begin
        if (idx >= POS_CHECK) begin
          // checksum byte is compared, never summed
          frm[POS_CHECK] = b;
          if (b == sum) begin
            got = 1'b1;
            r.pressure_raw    = {frm[POS_PRESS_HI], frm[POS_PRESS_LO]};
            r.temperature_raw = {frm[POS_TEMP_HI], frm[POS_TEMP_LO]};
            r.sensor_status   = frm[POS_STATUS];
          end
          restart_hunt();
        end else begin
          take_byte(b);
        end
      end
    endcase
  endtask

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 90) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'h00;
    if (r < 30) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic offer_byte(input logic [7:0] b);
    int g;
    g = (!calm && $urandom_range(0, 3) == 0) ? idle_len() : 0;
    if (g > 0) begin
      byte_if.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    byte_if.valid   <= 1'b1;
    byte_if.rx_byte <= b;
    do @(posedge clk); while (byte_if.ready !== 1'b1);
    bytes_sent++;
  endtask

  task automatic feed(input logic [7:0] b);
    bit      got;
    result_t r;
    offer_byte(b);
    deframe_byte(b, got, r);
    if (got)
      pending_pkts.push_back(r);
  endtask

  task automatic send_frame();
    logic [7:0] f [13];
    logic [7:0] s;
    int r, n;
    s = '0;
    for (int i = 0; i < 4; i++)
      f[i] = sync_cfg[8*i +: 8];
    f[POS_VERSION] = ver_cfg;
    for (int i = POS_VERSION + 1; i < POS_CHECK; i++)
      f[i] = pick_byte();
    for (int i = 0; i < POS_CHECK; i++)
      s = s + f[i];
    f[POS_CHECK] = s;
    n = 13;
    r = $urandom_range(0, 99);
    if (r < 8)
      f[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
    else if (r < 14)
      f[POS_VERSION] ^= 8'($urandom_range(1, 255));
    else if (r < 24)
      f[POS_CHECK] ^= 8'($urandom_range(1, 255));
    else if (r < 30)
      n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++)
      feed(f[i]);
  endtask

  // Hold the input until every packet is out and the byte pipeline is empty
  task automatic drain();
    byte_if.valid <= 1'b0;
    while (pending_pkts.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] ix, input logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= ix;
    cfg_wdata <= v;
    @(posedge clk);
    case (ix)
      CFG_SYNC_WORD:    sync_cfg = v;
      CFG_EXPECTED_VER: ver_cfg  = v[7:0];
      default: ;
    endcase
    n_writes++;
  endtask

  // Result side: random gaps, plus one long hold on request
  initial begin
    int hold_left;
    int sink_gap;
    hold_left = 0;
    sink_gap  = 0;
    pkt_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        pkt_if.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        pkt_if.ready <= 1'b0;
      end else begin
        pkt_if.ready <= 1'b1;
        if (!calm && $urandom_range(0, 9) == 0)
          sink_gap = idle_len();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && pkt_if.valid === 1'b1 && pkt_if.ready === 1'b1) begin
      if (pending_pkts.size() == 0) begin
        flag($sformatf("unexpected packet %h %h %h", pkt_if.pressure_raw,
                       pkt_if.temperature_raw, pkt_if.sensor_status));
      end else begin
        want_pkt = pending_pkts.pop_front();
        pkts_checked++;
        if (pkt_if.pressure_raw !== want_pkt.pressure_raw)
          flag($sformatf("pressure_raw %h, want %h", pkt_if.pressure_raw,
                         want_pkt.pressure_raw));
        if (pkt_if.temperature_raw !== want_pkt.temperature_raw)
          flag($sformatf("temperature_raw %h, want %h", pkt_if.temperature_raw,
                         want_pkt.temperature_raw));
        if (pkt_if.sensor_status !== want_pkt.sensor_status)
          flag($sformatf("sensor_status %h, want %h", pkt_if.sensor_status,
                         want_pkt.sensor_status));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb_top: timed out with %0d packets outstanding", pending_pkts.size());
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    bit      got;
    result_t r;
    int      n;
    byte_if.valid   <= 1'b0;
    byte_if.rx_byte <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_wdata       <= '0;
    sync_cfg = SYNC_WORD_RST;
    ver_cfg  = EXP_VER_RST;
    restart_hunt();
    for (int i = 0; i < 16; i++)
      frm[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      offer_byte(dir_tab[i].rx);
      deframe_byte(dir_tab[i].rx, got, r);
      case (dir_tab[i].kind)
        CHK_MODEL: if (got) pending_pkts.push_back(r);
        CHK_FRAME: pending_pkts.push_back(dir_tab[i].pkt);
        default: ;
      endcase
    end

    for (int p = 0; p < N_PHASES; p++) begin
      if (p > 0) begin
        drain();
        case (p)
          1: begin
            set_reg(CFG_SYNC_WORD, '0);
            set_reg(CFG_EXPECTED_VER, '0);
          end
          2: begin
            set_reg(CFG_SYNC_WORD, '1);
            set_reg(CFG_EXPECTED_VER, 32'h0000_00FF);
          end
          3: begin
            set_reg(CFG_SPARE_A, $urandom);
            set_reg(CFG_SPARE_B, $urandom);
            set_reg(CFG_SYNC_WORD, $urandom);
            set_reg(CFG_EXPECTED_VER, $urandom_range(0, 255));
          end
          4: begin
            set_reg(CFG_SYNC_WORD, $urandom);
            set_reg(CFG_EXPECTED_VER, $urandom_range(0, 255));
          end
          default: begin
            set_reg(CFG_SYNC_WORD, SYNC_WORD_RST);
            set_reg(CFG_EXPECTED_VER, {24'd0, EXP_VER_RST});
          end
        endcase
        cfg_we <= 1'b0;
      end
      calm = (p == 2);
      // stall the result side while bytes keep coming
      if (p == 4)
        hold_req = 1'b1;
      while (bytes_sent < N_DIR + (p + 1) * PHASE_LEN) begin
        if ($urandom_range(0, 4) == 0) begin
          n = $urandom_range(1, 5);
          repeat (n) feed(8'($urandom_range(0, 255)));
        end
        send_frame();
      end
    end

    byte_if.valid <= 1'b0;
    for (n = 0; n < 4000 && pending_pkts.size() != 0; n++)
      @(posedge clk);
    repeat (2 * DRAIN_GAP) @(posedge clk);
    if (pending_pkts.size() != 0)
      flag($sformatf("%0d packets never arrived", pending_pkts.size()));

    $display("tb_top: %0d bytes over %0d register writes, %0d packets compared",
             bytes_sent, n_writes, pkts_checked);
    $display("tb_top: %s %0d-cycle hold",
             "stream mixed good, corrupt and cut-short frames with noise and a", LONG_HOLD);
    if (n_errors == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
